// ===== rtl/core/cdw_pkg.sv =====
// Shared types and constants for the coupled digit wheel dialer.
package cdw_pkg;

  localparam logic OP_HOME = 1'b0;
  localparam logic OP_SHOW = 1'b1;

  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [15:0] TEN         = 16'd10;

  localparam int REC_SHIFT = 16;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HOME,
    B_ABOVE,
    B_OWN,
    B_DECIDE,
    B_DIAL,
    B_FINISH
  } back_state_t;

  typedef struct packed {
    logic        moved;
    logic        home_cmd;
    logic [15:0] step_target;
    logic        last;
  } cdw_result_t;

endpackage

// ===== rtl/core/cdw_if.sv =====
// Valid/ready channel interfaces for the dialer input and result streams.
interface cdw_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] number;

  modport source (output valid, output op, output number, input ready);
  modport sink (input valid, input op, input number, output ready);
endinterface

interface cdw_out_if;
  logic        valid;
  logic        ready;
  logic        moved;
  logic        home_cmd;
  logic [15:0] step_target;
  logic        last;

  modport source (output valid, output moved, output home_cmd, output step_target,
                  output last, input ready);
  modport sink (input valid, input moved, input home_cmd, input step_target,
                input last, output ready);
endinterface

// ===== rtl/core/coupled_digit_wheel_dialer.sv =====
// Top level of the coupled digit wheel dialer.
//
// Usage: commands arrive on in_ch (op 0 = home, op 1 = show number) and
// motor commands leave on out_ch, both valid/ready; a transaction moves
// when valid and ready are high at a rising clock edge.
// A home command yields one result with home_cmd set. A show command yields
// one result per wheel that must turn (moved set, step_target = position
// times STEPS_PER_SYMBOL), or a single no-move result; the final result of
// each command carries last.
// Work: the front end splits the number one digit per cycle through a
// reciprocal multiply for division by ten. For each wheel the back end
// uses one shared 8x16 multiplier for position modulo SYMBOLS_PER_WHEEL,
// then a decide step and, when the wheel must turn, a dial step; a home
// command needs no per-wheel steps.
// A two-entry queue lets the front end take the next command while the
// back end works. A dial result waits for the next dial or the finish step.
// Reset: all tracked wheel positions return to zero and the queue empties.
// When the receiver stalls, results wait in the output register and the
// back end holds; the front end and queue keep accepting until full.
module coupled_digit_wheel_dialer #(
  parameter int DIGIT_COUNT       = 4,
  parameter int SYMBOLS_PER_WHEEL = 10,
  parameter int STEPS_PER_SYMBOL  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cdw_in_if.sink    in_ch,
  cdw_out_if.source out_ch
);

  localparam int QW = 4 * DIGIT_COUNT + 1;

  logic                 fq_valid;
  logic                 fq_ready;
  logic [QW-1:0]        fq_data;
  logic                 qb_valid;
  logic                 qb_ready;
  logic [QW-1:0]        qb_data;
  cdw_pkg::cdw_result_t res;

  cdw_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  cdw_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  cdw_back #(
    .DIGIT_COUNT       (DIGIT_COUNT),
    .SYMBOLS_PER_WHEEL (SYMBOLS_PER_WHEEL),
    .STEPS_PER_SYMBOL  (STEPS_PER_SYMBOL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.moved       = res.moved;
  assign out_ch.home_cmd    = res.home_cmd;
  assign out_ch.step_target = res.step_target;
  assign out_ch.last        = res.last;

endmodule

// ===== rtl/core/cdw_front.sv =====
// Front end: accepts commands and splits the number into decimal digits.
module cdw_front #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  cdw_in_if.sink                   in_ch,
  output logic                     q_valid,
  input  logic                     q_ready,
  output logic [4*DIGIT_COUNT:0]   q_data
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

  cdw_pkg::front_state_t       state_r, state_nxt;
  logic                        op_r;
  logic [15:0]                 num_r;
  logic [IDX_W-1:0]            cnt_r;
  logic [DIGIT_COUNT-1:0][3:0] dig_r;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem16;

  always_comb begin
    prod  = 32'(num_r) * cdw_pkg::DIV10_MUL;
    quot  = 16'(prod >> cdw_pkg::DIV10_SHIFT);
    rem16 = num_r - 16'(quot * cdw_pkg::TEN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdw_pkg::F_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.op == cdw_pkg::OP_HOME) ? cdw_pkg::F_PUSH : cdw_pkg::F_SPLIT;
        end
      end
      cdw_pkg::F_SPLIT: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = cdw_pkg::F_PUSH;
        end
      end
      cdw_pkg::F_PUSH: begin
        if (q_ready) begin
          state_nxt = cdw_pkg::F_IDLE;
        end
      end
      default: state_nxt = cdw_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdw_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cdw_pkg::F_IDLE && in_ch.valid) begin
      op_r  <= in_ch.op;
      num_r <= in_ch.number;
      cnt_r <= '0;
    end else if (state_r == cdw_pkg::F_SPLIT) begin
      dig_r[cnt_r] <= rem16[3:0];
      num_r        <= quot;
      cnt_r        <= cnt_r + 1'b1;
    end
  end

  assign in_ch.ready = (state_r == cdw_pkg::F_IDLE);
  assign q_valid     = (state_r == cdw_pkg::F_PUSH);
  assign q_data      = {op_r, dig_r};

endmodule

// ===== rtl/core/cdw_queue.sv =====
// Two-entry queue between the front end and the wheel sequencer.
module cdw_queue #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ===== rtl/core/cdw_back.sv =====
// Back end: walks the digits, tracks wheel positions and emits step targets.
module cdw_back #(
  parameter int DIGIT_COUNT       = 4,
  parameter int SYMBOLS_PER_WHEEL = 10,
  parameter int STEPS_PER_SYMBOL  = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [4*DIGIT_COUNT:0] q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cdw_pkg::cdw_result_t   out_data
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DIGIT_COUNT - 1);
  localparam logic [7:0]  SYM8   = 8'(SYMBOLS_PER_WHEEL);
  localparam logic [7:0]  SM1_8  = 8'(SYMBOLS_PER_WHEEL - 1);
  localparam logic [8:0]  SM1_9  = 9'(SYMBOLS_PER_WHEEL - 1);
  localparam logic [15:0] REC    = 16'((1 << cdw_pkg::REC_SHIFT) / SYMBOLS_PER_WHEEL);
  localparam logic [16:0] STEPS  = 17'(STEPS_PER_SYMBOL);

  cdw_pkg::back_state_t        state_r, state_nxt;
  logic [DIGIT_COUNT-1:0][3:0] dig_r;
  logic [IDX_W-1:0]            d_r;
  logic [DIGIT_COUNT-1:0][7:0] wheel_r;
  logic [7:0]                  x_r;
  logic [23:0]                 prod_r;
  logic [7:0]                  above_r;
  logic [7:0]                  base_r;
  logic [7:0]                  total_r;
  logic                        pend_valid_r;
  cdw_pkg::cdw_result_t        pend_r;
  logic                        out_valid_r;
  cdw_pkg::cdw_result_t        out_r;

  logic                        take;
  logic                        cap_prod;
  logic                        cap_above;
  logic                        cap_total;
  logic                        step_dn;
  logic                        pend_set;
  logic                        pend_clr;
  logic                        wheel_dial;
  logic                        wheel_home;
  logic                        out_load;
  cdw_pkg::cdw_result_t        out_load_val;
  logic                        out_free;

  logic [IDX_W-1:0]            rd_idx;
  logic [7:0]                  rd_val;
  logic [23:0]                 prod_nxt;
  logic [7:0]                  rem_x;
  logic [7:0]                  sym8;
  logic                        is_top;
  logic [7:0]                  tgt;
  logic [7:0]                  offs;
  logic [7:0]                  total_nxt;
  logic                        move;
  logic [DIGIT_COUNT-1:0][7:0] wheel_new;
  logic [16:0]                 step_full;

  function automatic logic [7:0] rem_of(input logic [7:0] x, input logic [23:0] p);
    logic [7:0] q;
    logic [7:0] r;
    q = p[23:16];
    r = x - 8'(16'(q) * 16'(SYM8));
    if (r >= SYM8) begin
      r = r - SYM8;
    end
    return r;
  endfunction

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    rd_idx   = (state_r == cdw_pkg::B_ABOVE) ? IDX_W'(d_r + 1'b1) : d_r;
    rd_val   = wheel_r[rd_idx];
    prod_nxt = 24'(rd_val) * 24'(REC);
  end

  always_comb begin
    rem_x  = rem_of(x_r, prod_r);
    sym8   = {4'b0000, dig_r[d_r]};
    is_top = (d_r == TOP_IDX);
    if (is_top) begin
      tgt = sym8;
    end else begin
      tgt = base_r + sym8;
      if (tgt < above_r) begin
        tgt = tgt + SYM8;
      end
    end
    offs = 8'(16'(SM1_8) * 16'(d_r));
    if (tgt < x_r) begin
      total_nxt = tgt;
    end else begin
      total_nxt = tgt + offs;
    end
    move = (rem_x != sym8) && (tgt != x_r);
  end

  always_comb begin
    logic [7:0] prev;
    logic [7:0] cur;
    wheel_new    = wheel_r;
    wheel_new[0] = total_r;
    for (int i = 1; i < DIGIT_COUNT; i++) begin
      prev = wheel_new[i-1];
      cur  = wheel_new[i];
      if (cur > prev) begin
        cur = prev;
      end
      if (({1'b0, cur} + SM1_9) < {1'b0, prev}) begin
        cur = prev - SM1_8;
      end
      wheel_new[i] = cur;
    end
    step_full = 17'(total_r) * STEPS;
  end

  always_comb begin
    state_nxt    = state_r;
    q_ready      = 1'b0;
    take         = 1'b0;
    cap_prod     = 1'b0;
    cap_above    = 1'b0;
    cap_total    = 1'b0;
    step_dn      = 1'b0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    wheel_dial   = 1'b0;
    wheel_home   = 1'b0;
    out_load     = 1'b0;
    out_load_val = '0;
    case (state_r)
      cdw_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          take      = 1'b1;
          state_nxt = (q_data[4*DIGIT_COUNT] == cdw_pkg::OP_HOME) ?
                      cdw_pkg::B_HOME : cdw_pkg::B_OWN;
        end
      end
      cdw_pkg::B_HOME: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_load_val.home_cmd = 1'b1;
          out_load_val.last     = 1'b1;
          wheel_home            = 1'b1;
          state_nxt             = cdw_pkg::B_IDLE;
        end
      end
      cdw_pkg::B_ABOVE: begin
        cap_prod  = 1'b1;
        state_nxt = cdw_pkg::B_OWN;
      end
      cdw_pkg::B_OWN: begin
        cap_above = 1'b1;
        cap_prod  = 1'b1;
        state_nxt = cdw_pkg::B_DECIDE;
      end
      cdw_pkg::B_DECIDE: begin
        if (move) begin
          cap_total = 1'b1;
          state_nxt = cdw_pkg::B_DIAL;
        end else if (d_r == '0) begin
          state_nxt = cdw_pkg::B_FINISH;
        end else begin
          step_dn   = 1'b1;
          state_nxt = cdw_pkg::B_ABOVE;
        end
      end
      cdw_pkg::B_DIAL: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_load     = 1'b1;
            out_load_val = pend_r;
          end
          pend_set   = 1'b1;
          wheel_dial = 1'b1;
          if (d_r == '0) begin
            state_nxt = cdw_pkg::B_FINISH;
          end else begin
            step_dn   = 1'b1;
            state_nxt = cdw_pkg::B_ABOVE;
          end
        end
      end
      cdw_pkg::B_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_r) begin
            out_load_val = pend_r;
          end
          out_load_val.last = 1'b1;
          pend_clr          = 1'b1;
          state_nxt         = cdw_pkg::B_IDLE;
        end
      end
      default: state_nxt = cdw_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cdw_pkg::B_IDLE;
      wheel_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wheel_home) begin
        wheel_r <= '0;
      end else if (wheel_dial) begin
        wheel_r <= wheel_new;
      end
      if (pend_set) begin
        pend_valid_r <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dig_r <= q_data[4*DIGIT_COUNT-1:0];
      d_r   <= TOP_IDX;
    end else if (step_dn) begin
      d_r <= d_r - 1'b1;
    end
    if (cap_prod) begin
      x_r    <= rd_val;
      prod_r <= prod_nxt;
    end
    if (cap_above) begin
      above_r <= x_r;
      base_r  <= x_r - rem_of(x_r, prod_r);
    end
    if (cap_total) begin
      total_r <= total_nxt;
    end
    if (pend_set) begin
      pend_r.moved       <= 1'b1;
      pend_r.home_cmd    <= 1'b0;
      pend_r.step_target <= step_full[15:0];
      pend_r.last        <= 1'b0;
    end
    if (out_load) begin
      out_r <= out_load_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/cdw_checker.sv =====
// Port-level checks for the dialer and the bind that attaches them.
module cdw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        moved,
  input logic        home_cmd,
  input logic [15:0] step_target,
  input logic        last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(step_target) && $stable(last))
    else $error("result changed while stalled");

  a_home_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && home_cmd |-> last && !moved && step_target == 16'd0)
    else $error("home result malformed");

  a_nomove_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !moved |-> last && step_target == 16'd0)
    else $error("result without move is not final");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

endmodule

bind coupled_digit_wheel_dialer cdw_checker u_cdw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .moved       (out_ch.moved),
  .home_cmd    (out_ch.home_cmd),
  .step_target (out_ch.step_target),
  .last        (out_ch.last)
);
